### rtl/assert_macros.svh
// assertion macros shared by bdp_out_skid and the top level
// expects signals named clk and rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_AT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a check in the next
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/bdp_pkg.sv
// constants, types and field arithmetic for the beaver dot product share block
// arithmetic is over p = 2^64 - 59; no dependencies
package bdp_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned NUM_OPS = 7;
  localparam int unsigned TDATA_W = NUM_OPS * WORD_W;
  localparam int unsigned MUL_LAT = 8;

  localparam logic [WORD_W-1:0] FIELD_P = 64'hFFFF_FFFF_FFFF_FFC5;
  // 2^64 mod p
  localparam logic [WORD_W-1:0] FOLD_C  = 64'd59;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] data;
  } result_t;

  // reduce a 64-bit word below p
  function automatic logic [WORD_W-1:0] mod_canon(input logic [WORD_W-1:0] v);
    logic [WORD_W:0] t;
    t = {1'b0, v} + {1'b0, FOLD_C};
    return t[WORD_W] ? t[WORD_W-1:0] : v;
  endfunction

  // a + b mod p for canonical a, b
  function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    logic [WORD_W:0] s2;
    s  = {1'b0, a} + {1'b0, b};
    s2 = s + {1'b0, FOLD_C};
    return s2[WORD_W] ? s2[WORD_W-1:0] : s[WORD_W-1:0];
  endfunction

  // a - b mod p for canonical a, b
  function automatic logic [WORD_W-1:0] mod_sub(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] alt;
    diff = {1'b0, a} - {1'b0, b};
    alt  = diff[WORD_W-1:0] - FOLD_C;
    return diff[WORD_W] ? alt : diff[WORD_W-1:0];
  endfunction

endpackage

### rtl/bdp_mulmod.sv
// pipelined 64x64 multiply mod p = 2^64 - 59
// depends on bdp_pkg
module bdp_mulmod import bdp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] prod
);

  logic [31:0]  a_lo, a_hi, b_lo, b_hi;
  logic [63:0]  p00, p01, p10, p11;
  logic [64:0]  mid;
  logic [127:0] lohi;
  logic [127:0] full;
  logic [69:0]  hi59;
  logic [63:0]  lo_d;
  logic [69:0]  f1;
  logic [11:0]  h1_x59;
  logic [64:0]  f2;
  logic [63:0]  f3;

  assign a_lo = a[31:0];
  assign a_hi = a[63:32];
  assign b_lo = b[31:0];
  assign b_hi = b[63:32];

  assign h1_x59 = {6'b0, f1[69:64]} * 12'd59;

  always_ff @(posedge clk) begin
    if (en) begin
      // 32x32 partial products
      p00  <= a_lo * b_lo;
      p01  <= a_lo * b_hi;
      p10  <= a_hi * b_lo;
      p11  <= a_hi * b_hi;
      mid  <= {1'b0, p01} + {1'b0, p10};
      lohi <= {p11, p00};
      full <= lohi + {31'b0, mid, 32'b0};
      // fold the high word: 2^64 = 59 mod p
      hi59 <= {6'b0, full[127:64]} * 70'd59;
      lo_d <= full[63:0];
      f1   <= hi59 + {6'b0, lo_d};
      f2   <= {1'b0, f1[63:0]} + {53'b0, h1_x59};
      // carry out of the second fold leaves a tiny low word, no overflow here
      f3   <= f2[63:0] + (f2[64] ? FOLD_C : 64'd0);
      prod <= mod_canon(f3);
    end
  end

endmodule

### rtl/bdp_out_skid.sv
// result register with one skid entry on the output stream
// depends on bdp_pkg and assert_macros.svh
`include "assert_macros.svh"

module bdp_out_skid import bdp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  result_t           push,
  output logic              full,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata
);

  logic              out_valid;
  logic [WORD_W-1:0] out_data;
  logic              skid_valid;
  logic [WORD_W-1:0] skid_data;
  logic              take;

  assign take     = out_valid && m_tready;
  assign full     = skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!out_valid || take) begin
        out_data  <= push.data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push.data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_AT_CLK(a_skid_behind_main, skid_valid |-> out_valid, "skid entry without main entry")
  `ASSERT_AT_CLK(a_push_has_room, push.valid |-> !skid_valid, "result pushed while buffer full")

endmodule

### rtl/beaver_dot_product_share_mod_p.sv
// top level of the beaver dot product share block, party 0, mod 2^64 - 59
// depends on bdp_pkg, bdp_mulmod, bdp_out_skid and assert_macros.svh
//
// Takes one vector element per clock on the s_ stream while s_tready is
// high and returns party 0's share of the dot product on the m_ stream once
// per vector, after the element with s_tlast set. The datapath is a fixed
// pipeline: input register, canonicalize, subtract, add, eight stages of
// modular multiply (32-bit partial products and three folds of the high
// word), two term adds and the accumulator, whose sum is registered on the
// output. The output has a result register and one skid entry; s_tready
// drops only while both hold a result not yet taken.
`include "assert_macros.svh"

module beaver_dot_product_share_mod_p import bdp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // share_a, share_b, mask_x, mask_y, mask_z, peer_d, peer_e (64 bits each)
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // dot_share
  output logic [WORD_W-1:0]  m_tdata
);

  logic              en;
  logic              full;
  result_t           push;

  // input register
  logic              v0, l0;
  logic [WORD_W-1:0] sa0, sb0, mx0, my0, mz0, pd0, pe0;
  // canonical operands
  logic              v1, l1;
  logic [WORD_W-1:0] sa1, sb1, mx1, my1, mz1, pd1, pe1;
  // differences
  logic              v2, l2;
  logic [WORD_W-1:0] td2, te2, mx2, my2, mz2, pd2, pe2;
  // openings
  logic              v3, l3;
  logic [WORD_W-1:0] d3, e3, mx3, my3, mz3;
  // side line along the multipliers
  logic [MUL_LAT-1:0] vline, lline;
  logic [WORD_W-1:0]  zline [MUL_LAT];
  logic               vm, lm;
  logic [WORD_W-1:0]  zm, prod_ex, prod_dy;
  // term adds
  logic              v4, l4;
  logic [WORD_W-1:0] t4, m4;
  logic              v5, l5;
  logic [WORD_W-1:0] t5;
  // accumulator
  logic [WORD_W-1:0] running_sum;
  logic [WORD_W-1:0] running_sum_next;

  assign en       = !full;
  assign s_tready = en;

  assign vm = vline[MUL_LAT-1];
  assign lm = lline[MUL_LAT-1];
  assign zm = zline[MUL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      vline <= '0;
      v4    <= 1'b0;
      v5    <= 1'b0;
    end else if (en) begin
      v0    <= s_tvalid;
      v1    <= v0;
      v2    <= v1;
      v3    <= v2;
      vline <= {vline[MUL_LAT-2:0], v3};
      v4    <= vm;
      v5    <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0  <= s_tlast;
      sa0 <= s_tdata[0*WORD_W +: WORD_W];
      sb0 <= s_tdata[1*WORD_W +: WORD_W];
      mx0 <= s_tdata[2*WORD_W +: WORD_W];
      my0 <= s_tdata[3*WORD_W +: WORD_W];
      mz0 <= s_tdata[4*WORD_W +: WORD_W];
      pd0 <= s_tdata[5*WORD_W +: WORD_W];
      pe0 <= s_tdata[6*WORD_W +: WORD_W];

      l1  <= l0;
      sa1 <= mod_canon(sa0);
      sb1 <= mod_canon(sb0);
      mx1 <= mod_canon(mx0);
      my1 <= mod_canon(my0);
      mz1 <= mod_canon(mz0);
      pd1 <= mod_canon(pd0);
      pe1 <= mod_canon(pe0);

      l2  <= l1;
      td2 <= mod_sub(sa1, mx1);
      te2 <= mod_sub(sb1, my1);
      mx2 <= mx1;
      my2 <= my1;
      mz2 <= mz1;
      pd2 <= pd1;
      pe2 <= pe1;

      l3  <= l2;
      d3  <= mod_add(td2, pd2);
      e3  <= mod_add(te2, pe2);
      mx3 <= mx2;
      my3 <= my2;
      mz3 <= mz2;

      lline <= {lline[MUL_LAT-2:0], l3};
      zline[0] <= mz3;
      for (int i = 1; i < MUL_LAT; i++) begin
        zline[i] <= zline[i-1];
      end

      l4 <= lm;
      t4 <= mod_add(zm, prod_ex);
      m4 <= prod_dy;

      l5 <= l4;
      t5 <= mod_add(t4, m4);
    end
  end

  bdp_mulmod u_mul_ex (
    .clk  (clk),
    .en   (en),
    .a    (e3),
    .b    (mx3),
    .prod (prod_ex)
  );

  bdp_mulmod u_mul_dy (
    .clk  (clk),
    .en   (en),
    .a    (d3),
    .b    (my3),
    .prod (prod_dy)
  );

  assign running_sum_next = mod_add(running_sum, t5);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (en && v5) begin
      running_sum <= l5 ? '0 : running_sum_next;
    end
  end

  always_comb begin
    push.valid = en && v5 && l5;
    push.data  = running_sum_next;
  end

  bdp_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `ASSERT_AT_CLK(a_sum_canonical, running_sum < FIELD_P, "running sum not below p")
  `ASSERT_NEXT(a_sum_cleared, en && v5 && l5, running_sum == '0, "sum not cleared after last")
  `ASSERT_AT_CLK(a_prod_canonical, vm |-> (prod_ex < FIELD_P && prod_dy < FIELD_P), "product not below p")

endmodule
